[rtl/cro_pkg.sv]
// Shared types and constants for the case-range overlap checker.
// Request codes, controller states, bound-flag positions and the match struct.
// No dependencies.
`default_nettype none

package cro_pkg;

	// Request codes carried on req_type
	typedef enum logic [1:0] {
		REQ_VALUE = 2'd0,
		REQ_RANGE = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} cro_req_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} cro_state_t;

	// Bit positions inside the two-bit bound-flag field
	localparam int FLAG_LOW  = 0;
	localparam int FLAG_HIGH = 1;

	// Keys are stored with the sign bit inverted so unsigned order is signed order
	localparam logic [63:0] SIGN_FLIP = 64'h8000_0000_0000_0000;

	// Per-entry compare outcome handed from the matcher to the controller
	typedef struct packed {
		logic range_hit;
		logic value_hit;
	} cro_match_t;

endpackage

`default_nettype wire

[rtl/cro_ram.sv]
// Simple dual-port table memory: one write port, one read port, registered read.
// Used for both the range table and the value table. No package dependency.
`default_nettype none

module cro_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/cro_match.sv]
// Compare logic for one stored range and one stored value against the request.
// Depends on cro_pkg for request codes, flag positions and the match struct.
`default_nettype none

module cro_match
	import cro_pkg::*;
(
	input  wire cro_req_t    req_kind,
	input  wire logic [1:0]  req_flags,
	input  wire logic [63:0] req_lo,
	input  wire logic [63:0] req_hi,
	input  wire logic [1:0]  ent_flags,
	input  wire logic [63:0] ent_lo,
	input  wire logic [63:0] ent_hi,
	input  wire logic [63:0] ent_value,
	input  wire logic        have_best,
	input  wire logic [63:0] best,
	output cro_match_t       hit
);

	logic req_empty;
	logic ent_empty;
	logic ent_holds_key;
	logic req_holds_val;
	logic disjoint;

	// Emptiness of both ranges: both bounds given and lower above upper
	assign req_empty = req_flags[FLAG_LOW] && req_flags[FLAG_HIGH] && (req_lo > req_hi);
	assign ent_empty = ent_flags[FLAG_LOW] && ent_flags[FLAG_HIGH] && (ent_lo > ent_hi);

	// Stored range holds the requested single key
	assign ent_holds_key = !(ent_flags[FLAG_LOW] && (req_lo < ent_lo))
		&& !(ent_flags[FLAG_HIGH] && (req_lo > ent_hi));

	// Requested range holds the stored single value
	assign req_holds_val = !(req_flags[FLAG_LOW] && (ent_value < req_lo))
		&& !(req_flags[FLAG_HIGH] && (ent_value > req_hi));

	// Standard interval separation test
	assign disjoint = (req_flags[FLAG_LOW] && ent_flags[FLAG_HIGH] && (req_lo > ent_hi))
		|| (ent_flags[FLAG_LOW] && req_flags[FLAG_HIGH] && (ent_lo > req_hi));

	// Select the test by request kind
	always_comb begin
		hit = '0;
		unique case (req_kind)
			REQ_VALUE: begin
				hit.range_hit = !ent_empty && ent_holds_key;
				hit.value_hit = (ent_value == req_lo);
			end
			REQ_RANGE: begin
				hit.range_hit = !req_empty && !ent_empty && !disjoint;
				hit.value_hit = !req_empty && req_holds_val && (!have_best || ent_value < best);
			end
			default: begin
				hit = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/case_range_overlap_checker_top.sv]
// Case-range overlap checker top level: request controller and the two tables.
// Depends on cro_pkg, cro_ram and cro_match.
//
// Usage:
//   A request is taken when start is high and busy is low. req_type selects a
//   single-value insert, a range insert or a clear of both tables.
//   Each request yields one result beat, shown for exactly one cycle with done
//   high: range_hit/range_hit_tag (oldest conflicting range), value_hit/
//   value_hit_tag (equal value, or smallest value inside the range) and
//   table_full (entry dropped because its table has no room).
//   Both tables are scanned side by side, one entry of each per cycle through
//   a registered read port, until every stored range and value has been read;
//   then the finish state writes the new entry back unless it hit or its table
//   is full. Clear and the unused code skip the scan and go straight to finish.
//   The new entry is written back in the cycle before done; busy drops with
//   done, so the next request may be taken in the cycle done is shown.
//   Reset empties both tables by clearing the fill counts; table contents are
//   not cleared. The receiver cannot stall: each result beat is lost if not
//   taken in its cycle.
`default_nettype none

module case_range_overlap_checker_top
	import cro_pkg::*;
#(
	parameter int RANGE_ENTRIES = 64,
	parameter int VALUE_ENTRIES = 64,
	parameter int TAG_BITS      = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic        low_present,
	input  wire logic [63:0] low_value,
	input  wire logic        high_present,
	input  wire logic [63:0] high_value,
	input  wire logic [15:0] item_tag,
	output logic             done,
	output logic             range_hit,
	output logic [15:0]      range_hit_tag,
	output logic             value_hit,
	output logic [15:0]      value_hit_tag,
	output logic             table_full
);

	// Stored tag width: results carry at most 16 tag bits
	localparam int TW  = (TAG_BITS < 16) ? TAG_BITS : 16;
	localparam int RAW = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
	localparam int VAW = (VALUE_ENTRIES > 1) ? $clog2(VALUE_ENTRIES) : 1;
	localparam int RCW = $clog2(RANGE_ENTRIES + 1);
	localparam int VCW = $clog2(VALUE_ENTRIES + 1);
	localparam int RROW = 2 + 64 + 64 + TW;
	localparam int VROW = 64 + TW;

	cro_state_t state_q, state_d;

	// Request held for the whole scan
	cro_req_t    req_q;
	logic [1:0]  flags_q;
	logic [63:0] lo_q;
	logic [63:0] hi_q;
	logic [TW-1:0] tag_q;

	// Fill counts and scan pointers
	logic [RCW-1:0] rcount_q, ridx_q;
	logic [VCW-1:0] vcount_q, vidx_q;
	logic           r_vld_s1, v_vld_s1;

	// Running results
	logic          rhit_q, vhit_q;
	logic [TW-1:0] rtag_q, vtag_q;
	logic [63:0]   best_q;

	// Result beat registers
	logic          done_q, range_hit_q, value_hit_q, full_q;
	logic [TW-1:0] range_tag_q, value_tag_q;

	logic r_issue, v_issue, scan_end, r_room, v_room, r_we, v_we, full_d, accept;
	logic [RROW-1:0] r_rdata, r_wdata;
	logic [VROW-1:0] v_rdata, v_wdata;
	cro_match_t      match;

	assign accept   = start && !busy;
	assign r_issue  = (state_q == ST_SCAN) && (ridx_q < rcount_q);
	assign v_issue  = (state_q == ST_SCAN) && (vidx_q < vcount_q);
	assign scan_end = !r_issue && !v_issue && !r_vld_s1 && !v_vld_s1;
	assign r_room   = rcount_q < RCW'(RANGE_ENTRIES);
	assign v_room   = vcount_q < VCW'(VALUE_ENTRIES);

	// Write-back of the new entry in the finish state
	assign r_we   = (state_q == ST_FINISH) && (req_q == REQ_RANGE) && !rhit_q && r_room;
	assign v_we   = (state_q == ST_FINISH) && (req_q == REQ_VALUE) && !vhit_q && v_room;
	assign full_d = (req_q == REQ_RANGE && !rhit_q && !r_room)
		|| (req_q == REQ_VALUE && !vhit_q && !v_room);

	assign r_wdata = {flags_q, lo_q, hi_q, tag_q};
	assign v_wdata = {lo_q, tag_q};

	cro_ram #(.WIDTH(RROW), .DEPTH(RANGE_ENTRIES), .AW(RAW)) u_range_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (rcount_q[RAW-1:0]),
		.wdata (r_wdata),
		.raddr (ridx_q[RAW-1:0]),
		.rdata (r_rdata)
	);

	cro_ram #(.WIDTH(VROW), .DEPTH(VALUE_ENTRIES), .AW(VAW)) u_value_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (vcount_q[VAW-1:0]),
		.wdata (v_wdata),
		.raddr (vidx_q[VAW-1:0]),
		.rdata (v_rdata)
	);

	cro_match u_match (
		.req_kind  (req_q),
		.req_flags (flags_q),
		.req_lo    (lo_q),
		.req_hi    (hi_q),
		.ent_flags (r_rdata[RROW-1 -: 2]),
		.ent_lo    (r_rdata[TW+127 -: 64]),
		.ent_hi    (r_rdata[TW+63 -: 64]),
		.ent_value (v_rdata[VROW-1 -: 64]),
		.have_best (vhit_q),
		.best      (best_q),
		.hit       (match)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and busy
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (req_type == REQ_VALUE || req_type == REQ_RANGE) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Latch the request beat
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= cro_req_t'(req_type);
			flags_q <= {high_present, low_present};
			lo_q    <= low_value ^ SIGN_FLIP;
			hi_q    <= high_value ^ SIGN_FLIP;
			tag_q   <= item_tag[TW-1:0];
		end
	end

	// Advance scan pointers, fill counts and running hits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcount_q <= '0;
			vcount_q <= '0;
			ridx_q   <= '0;
			vidx_q   <= '0;
			r_vld_s1 <= 1'b0;
			v_vld_s1 <= 1'b0;
			rhit_q   <= 1'b0;
			vhit_q   <= 1'b0;
		end else begin
			r_vld_s1 <= r_issue;
			v_vld_s1 <= v_issue;
			if (accept) begin
				ridx_q <= '0;
				vidx_q <= '0;
				rhit_q <= 1'b0;
				vhit_q <= 1'b0;
			end else begin
				if (r_issue) begin
					ridx_q <= ridx_q + 1'b1;
				end
				if (v_issue) begin
					vidx_q <= vidx_q + 1'b1;
				end
				if (r_vld_s1 && match.range_hit) begin
					rhit_q <= 1'b1;
				end
				if (v_vld_s1 && match.value_hit) begin
					vhit_q <= 1'b1;
				end
			end
			if (state_q == ST_FINISH) begin
				if (req_q == REQ_CLEAR) begin
					rcount_q <= '0;
					vcount_q <= '0;
				end
				if (r_we) begin
					rcount_q <= rcount_q + 1'b1;
				end
				if (v_we) begin
					vcount_q <= vcount_q + 1'b1;
				end
			end
		end
	end

	// Hold the tag of the first conflicting range and of the best value
	always_ff @(posedge clk) begin
		if (accept) begin
			rtag_q <= '0;
			vtag_q <= '0;
			best_q <= '0;
		end else begin
			if (r_vld_s1 && match.range_hit && !rhit_q) begin
				rtag_q <= r_rdata[TW-1:0];
			end
			if (v_vld_s1 && match.value_hit) begin
				vtag_q <= v_rdata[TW-1:0];
				best_q <= v_rdata[VROW-1 -: 64];
			end
		end
	end

	// Result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			range_hit_q <= 1'b0;
			value_hit_q <= 1'b0;
			full_q      <= 1'b0;
			range_tag_q <= '0;
			value_tag_q <= '0;
		end else begin
			done_q <= (state_q == ST_FINISH);
			if (state_q == ST_FINISH) begin
				range_hit_q <= rhit_q;
				value_hit_q <= vhit_q;
				full_q      <= full_d;
				range_tag_q <= rtag_q;
				value_tag_q <= vtag_q;
			end
		end
	end

	assign done          = done_q;
	assign range_hit     = range_hit_q;
	assign value_hit     = value_hit_q;
	assign table_full    = full_q;
	assign range_hit_tag = 16'(range_tag_q);
	assign value_hit_tag = 16'(value_tag_q);

	// A result beat only follows the write-back cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FINISH))
		else $error("result beat without a finished request");

	// Fill counts never pass the table depth
	assert property (@(posedge clk) disable iff (!arst_n)
		(rcount_q <= RCW'(RANGE_ENTRIES)) && (vcount_q <= VCW'(VALUE_ENTRIES)))
		else $error("fill count beyond table depth");

	// A dropped entry cannot also have hit in both tables
	assert property (@(posedge clk) disable iff (!arst_n)
		done && table_full |-> !(range_hit && value_hit))
		else $error("table_full with both hits set");

	// The range tag reads zero when its hit is clear
	assert property (@(posedge clk) disable iff (!arst_n)
		done && !range_hit |-> range_hit_tag == 16'd0)
		else $error("range tag without range hit");

	// An accepted request keeps the block busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

endmodule

`default_nettype wire

[tb/tb_case_range_overlap_checker_top.sv]
// Self-checking testbench for case_range_overlap_checker_top.
// Depends on cro_pkg and the checker RTL; a built-in table predictor scores every result beat.
`timescale 1ns / 1ps

module tb_case_range_overlap_checker_top
	import cro_pkg::*;
();

	localparam int RANGE_DEPTH    = 64;
	localparam int VALUE_DEPTH    = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 80;
	localparam int RANDOM_ITEMS   = 1000;

	typedef logic signed [63:0] key_t;

	localparam key_t KEY_MIN = 64'h8000_0000_0000_0000;
	localparam key_t KEY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic        range_hit;
		logic [15:0] range_hit_tag;
		logic        value_hit;
		logic [15:0] value_hit_tag;
		logic        table_full;
	} conflict_report_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic        low_present;
	logic [63:0] low_value;
	logic        high_present;
	logic [63:0] high_value;
	logic [15:0] item_tag;
	logic        done;
	logic        range_hit;
	logic [15:0] range_hit_tag;
	logic        value_hit;
	logic [15:0] value_hit_tag;
	logic        table_full;

	// Mirror of the two tables
	key_t        span_lo [RANGE_DEPTH];
	key_t        span_hi [RANGE_DEPTH];
	logic [1:0]  span_flags [RANGE_DEPTH];
	logic [15:0] span_tag [RANGE_DEPTH];
	int          span_count = 0;
	key_t        key_val [VALUE_DEPTH];
	logic [15:0] key_tag [VALUE_DEPTH];
	int          key_count = 0;

	conflict_report_t reports_due[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int idle_pct = 30;

	case_range_overlap_checker_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.low_present  (low_present),
		.low_value    (low_value),
		.high_present (high_present),
		.high_value   (high_value),
		.item_tag     (item_tag),
		.done         (done),
		.range_hit    (range_hit),
		.range_hit_tag(range_hit_tag),
		.value_hit    (value_hit),
		.value_hit_tag(value_hit_tag),
		.table_full   (table_full)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Interval helpers: a bound only counts when its flag is set
	function automatic bit bounds_empty(logic [1:0] fl, key_t lo, key_t hi);
		return fl[FLAG_LOW] && fl[FLAG_HIGH] && (lo > hi);
	endfunction

	function automatic bit bounds_hold(logic [1:0] fl, key_t lo, key_t hi, key_t v);
		return !(fl[FLAG_LOW] && v < lo) && !(fl[FLAG_HIGH] && v > hi);
	endfunction

	function automatic bit spans_overlap(logic [1:0] fa, key_t la, key_t ha,
			logic [1:0] fb, key_t lb, key_t hb);
		if (bounds_empty(fa, la, ha) || bounds_empty(fb, lb, hb))
			return 1'b0;
		if (fa[FLAG_LOW] && fb[FLAG_HIGH] && la > hb)
			return 1'b0;
		if (fb[FLAG_LOW] && fa[FLAG_HIGH] && lb > ha)
			return 1'b0;
		return 1'b1;
	endfunction

	// Work out the conflicts of one request and update the mirrored tables
	function automatic conflict_report_t predict_conflicts(cro_req_t req, logic lp, key_t lo,
			logic hp, key_t hi, logic [15:0] tag);
		conflict_report_t rep;
		logic [1:0] fl;
		key_t least;
		int i;
		rep = '0;
		fl = '0;
		fl[FLAG_LOW] = lp;
		fl[FLAG_HIGH] = hp;
		least = '0;
		case (req)
			REQ_CLEAR: begin
				span_count = 0;
				key_count = 0;
			end
			REQ_VALUE: begin
				// oldest non-empty range holding the value
				for (i = 0; i < span_count && !rep.range_hit; i++) begin
					if (!bounds_empty(span_flags[i], span_lo[i], span_hi[i]) &&
							bounds_hold(span_flags[i], span_lo[i], span_hi[i], lo)) begin
						rep.range_hit = 1'b1;
						rep.range_hit_tag = span_tag[i];
					end
				end
				for (i = 0; i < key_count && !rep.value_hit; i++) begin
					if (key_val[i] == lo) begin
						rep.value_hit = 1'b1;
						rep.value_hit_tag = key_tag[i];
					end
				end
				if (!rep.value_hit) begin
					if (key_count < VALUE_DEPTH) begin
						key_val[key_count] = lo;
						key_tag[key_count] = tag;
						key_count++;
					end else begin
						rep.table_full = 1'b1;
					end
				end
			end
			REQ_RANGE: begin
				// smallest stored value inside a non-empty range
				if (!bounds_empty(fl, lo, hi)) begin
					for (i = 0; i < key_count; i++) begin
						if (bounds_hold(fl, lo, hi, key_val[i]) &&
								(!rep.value_hit || key_val[i] < least)) begin
							rep.value_hit = 1'b1;
							rep.value_hit_tag = key_tag[i];
							least = key_val[i];
						end
					end
				end
				for (i = 0; i < span_count && !rep.range_hit; i++) begin
					if (spans_overlap(fl, lo, hi, span_flags[i], span_lo[i], span_hi[i])) begin
						rep.range_hit = 1'b1;
						rep.range_hit_tag = span_tag[i];
					end
				end
				if (!rep.range_hit) begin
					if (span_count < RANGE_DEPTH) begin
						span_lo[span_count] = lo;
						span_hi[span_count] = hi;
						span_flags[span_count] = fl;
						span_tag[span_count] = tag;
						span_count++;
					end else begin
						rep.table_full = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return rep;
	endfunction

	// Send one request beat, hold it until taken, then maybe idle for a burst
	task automatic issue_request(cro_req_t req, logic lp, key_t lo, logic hp, key_t hi,
			logic [15:0] tag);
		start <= 1'b1;
		req_type <= req;
		low_present <= lp;
		low_value <= lo;
		high_present <= hp;
		high_value <= hi;
		item_tag <= tag;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		reports_due.insert(reports_due.size(), predict_conflicts(req, lp, lo, hp, hi, tag));
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Value request with random bits on the fields it ignores
	task automatic ask_value(key_t v, logic [15:0] tag);
		issue_request(REQ_VALUE, 1'($urandom_range(0, 1)), v, 1'($urandom_range(0, 1)),
			{$urandom, $urandom}, tag);
	endtask

	task automatic ask_clear();
		issue_request(REQ_CLEAR, 1'($urandom_range(0, 1)), {$urandom, $urandom},
			1'($urandom_range(0, 1)), {$urandom, $urandom}, 16'($urandom));
	endtask

	// Pick a key: a narrow window for dense collisions, or the whole space
	function automatic key_t draw_key(bit wide);
		int pick;
		int j;
		key_t k;
		pick = $urandom_range(0, 99);
		k = {$urandom, $urandom};
		if (!wide) begin
			k = $urandom_range(0, 48);
			k = k - 24;
		end else if (pick < 15) begin
			case ($urandom_range(0, 3))
				0: k = KEY_MIN;
				1: k = KEY_MAX;
				2: k = '0;
				default: k = -1;
			endcase
		end else if (pick < 40 && key_count > 0) begin
			j = $urandom_range(0, key_count - 1);
			k = key_val[j] + $signed($urandom_range(0, 2)) - 1;
		end else if (pick < 60 && span_count > 0) begin
			j = $urandom_range(0, span_count - 1);
			k = span_flags[j][FLAG_LOW] ? span_lo[j] : span_hi[j];
		end
		return k;
	endfunction

	// Extremes of the key space and repeated values
	task automatic test_value_extremes();
		ask_clear();
		ask_value(KEY_MIN, 16'h0001);
		ask_value(KEY_MAX, 16'hFFFF);
		ask_value('0, 16'h0003);
		ask_value(KEY_MIN, 16'h00AA);
		ask_value(-1, 16'h8000);
	endtask

	// Open bounds, empty ranges, containment both ways, range hits on values
	task automatic test_range_bounds();
		issue_request(REQ_RANGE, 1'b0, {$urandom, $urandom}, 1'b0, {$urandom, $urandom}, 16'h0101);
		issue_request(REQ_RANGE, 1'b1, 5, 1'b1, 10, 16'h0102);
		ask_clear();
		issue_request(REQ_RANGE, 1'b1, 10, 1'b1, 5, 16'h0201);
		issue_request(REQ_RANGE, 1'b1, '0, 1'b1, '0, 16'h0202);
		ask_value('0, 16'h0203);
		issue_request(REQ_RANGE, 1'b1, -5, 1'b0, {$urandom, $urandom}, 16'h0204);
		issue_request(REQ_RANGE, 1'b0, {$urandom, $urandom}, 1'b1, -1, 16'h0205);
		ask_value(KEY_MIN, 16'h0206);
		issue_request(REQ_RANGE, 1'b1, -100, 1'b1, 100, 16'h0207);
		issue_request(REQ_RANGE, 1'b1, -3, 1'b1, -2, 16'h0208);
		issue_request(REQ_RANGE, 1'b1, 100, 1'b1, -100, 16'h0209);
		issue_request(REQ_RANGE, 1'b1, KEY_MAX, 1'b1, KEY_MAX, 16'h020A);
	endtask

	// Clear and the unused code both report nothing
	task automatic test_idle_codes();
		issue_request(REQ_NONE, 1'b1, '0, 1'b1, '0, 16'hFFFF);
		issue_request(REQ_NONE, 1'b0, KEY_MIN, 1'b0, KEY_MAX, 16'h0000);
		ask_clear();
		ask_value('0, 16'h0301);
	endtask

	// Fill each table to the last entry, then overflow it
	task automatic test_table_limits();
		key_t k;
		key_t hold;
		int i;
		ask_clear();
		for (i = 0; i < VALUE_DEPTH; i++) begin
			k = {$urandom, $urandom};
			k[63:56] = 8'(i);
			ask_value(k, 16'($urandom));
		end
		hold = k;
		k[63:56] = 8'hFF;
		ask_value(k, 16'($urandom));
		ask_value(hold, 16'($urandom));
		// disjoint ranges, every eighth one empty
		for (i = 0; i < RANGE_DEPTH; i++) begin
			k = key_t'(i) <<< 48;
			if (i % 8 == 7)
				issue_request(REQ_RANGE, 1'b1, k, 1'b1, k - 1, 16'($urandom));
			else
				issue_request(REQ_RANGE, 1'b1, k, 1'b1, k + $urandom_range(0, 1 << 30),
					16'($urandom));
		end
		k = 64'h7000_0000_0000_0000;
		issue_request(REQ_RANGE, 1'b1, k, 1'b1, k + 10, 16'($urandom));
		issue_request(REQ_RANGE, 1'b1, '0, 1'b0, '0, 16'($urandom));
		ask_clear();
	endtask

	// Runs of random traffic, each in a narrow or a wide key space
	task automatic test_random_traffic(int quota);
		int sent;
		int run_len;
		int pick;
		bit wide;
		logic lp;
		logic hp;
		key_t lo;
		key_t hi;
		sent = 0;
		while (sent < quota) begin
			wide = ($urandom_range(0, 2) != 0);
			run_len = $urandom_range(20, 160);
			idle_pct = (sent >= quota - 200 || $urandom_range(0, 3) == 0) ? 0 :
				$urandom_range(5, 60);
			if ($urandom_range(0, 3) != 0) begin
				ask_clear();
				sent++;
			end
			repeat (run_len) begin
				if (sent >= quota - 200)
					idle_pct = 0;
				pick = $urandom_range(0, 99);
				if (pick < 46) begin
					ask_value(draw_key(wide), 16'($urandom));
				end else if (pick < 92) begin
					lp = ($urandom_range(0, 9) != 0);
					hp = ($urandom_range(0, 9) != 0);
					lo = draw_key(wide);
					if ($urandom_range(0, 6) == 0)
						hi = draw_key(wide);
					else
						hi = lo + (wide ? $urandom_range(0, 1 << 20) : $urandom_range(0, 6));
					issue_request(REQ_RANGE, lp, lo, hp, hi, 16'($urandom));
				end else if (pick < 96) begin
					ask_clear();
				end else begin
					issue_request(REQ_NONE, 1'($urandom_range(0, 1)), {$urandom, $urandom},
						1'($urandom_range(0, 1)), {$urandom, $urandom}, 16'($urandom));
				end
				sent++;
			end
		end
	endtask

	// Score each result beat against the oldest prediction; guard against a hang
	always @(posedge clk) begin : score_results
		conflict_report_t due;
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("case_range_overlap_checker_top test failed");
				$finish;
			end else if (done) begin
				if (reports_due.size() == 0) begin
					$error("result beat with no request outstanding");
					mismatch_count++;
				end else begin
					due = reports_due.pop_front();
					if (range_hit !== due.range_hit) begin
						$error("range_hit: expected %0d, got %0d", due.range_hit, range_hit);
						mismatch_count++;
					end
					if (range_hit_tag !== due.range_hit_tag) begin
						$error("range_hit_tag: expected %0h, got %0h",
							due.range_hit_tag, range_hit_tag);
						mismatch_count++;
					end
					if (value_hit !== due.value_hit) begin
						$error("value_hit: expected %0d, got %0d", due.value_hit, value_hit);
						mismatch_count++;
					end
					if (value_hit_tag !== due.value_hit_tag) begin
						$error("value_hit_tag: expected %0h, got %0h",
							due.value_hit_tag, value_hit_tag);
						mismatch_count++;
					end
					if (table_full !== due.table_full) begin
						$error("table_full: expected %0d, got %0d", due.table_full, table_full);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_NONE;
		low_present <= 1'b0;
		low_value <= '0;
		high_present <= 1'b0;
		high_value <= '0;
		item_tag <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_value_extremes();
		test_range_bounds();
		test_idle_codes();
		test_table_limits();
		test_random_traffic(RANDOM_ITEMS);

		// drain the outstanding beats, then watch for strays
		start <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("case_range_overlap_checker_top test passed");
		else
			$display("case_range_overlap_checker_top test failed");
		$finish;
	end

endmodule
